// File: sv/bxf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the 3x3 box filter.
package bxf_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ROW_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam int ROW_WIDTH_RST = 1024;
    localparam int ROW_COUNT_RST = 1026;

    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 2'd1;

    // Position flags that travel with a word from the accept stage to the window.
    typedef struct packed {
        logic rows_ready;   // two rows above are in the line buffers
        logic first_col;
        logic second_col;
        logic last_col;
        logic frame_end;
    } t_item_flags;

endpackage

// File: sv/bxf_line_mem.sv
`timescale 1ns / 1ps
// Line buffer memory: one write port, one read port, registered read data.
module bxf_line_mem #(
    parameter int DEPTH     = bxf_pkg::MAX_WIDTH_DEF,
    parameter int DATA_BITS = 2 * bxf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0]     o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0]     i_wr_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: sv/bxf_window.sv
`timescale 1ns / 1ps
// Column-sum window, result slots and divide-by-nine output stage.
module bxf_window #(
    parameter int SAMPLE_BITS = bxf_pkg::SAMPLE_BITS_DEF,
    parameter int COL_BITS    = $clog2(bxf_pkg::MAX_WIDTH_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_s1_valid,
    output logic                          o_take,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [SAMPLE_BITS-1:0]        i_above,
    input  logic [SAMPLE_BITS-1:0]        i_two_above,
    input  logic [COL_BITS-1:0]           i_col,
    input  logic [bxf_pkg::ROW_BITS-1:0]  i_row,
    input  bxf_pkg::t_item_flags          i_flags,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [SAMPLE_BITS-1:0]        o_value,
    output logic [bxf_pkg::ROW_BITS-1:0]  o_out_row,
    output logic [COL_BITS-1:0]           o_out_col,
    output logic                          o_last_of_input,
    output logic                          o_last_of_frame
);

    localparam int CS_BITS    = SAMPLE_BITS + 2;
    localparam int SUM_BITS   = SAMPLE_BITS + 4;
    localparam int K          = SUM_BITS + 3;
    localparam int RECIP_BITS = K - 2;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    // ceil(2^K / 9): exact floor division for every sum below 2^SUM_BITS
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << K) + 64'd8) / 64'd9);

    logic [CS_BITS-1:0] r_cs_prev;
    logic [CS_BITS-1:0] r_cs_last;

    logic                          r_a_v;
    logic                          r_b_v;
    logic [SUM_BITS-1:0]           r_a_sum;
    logic [SUM_BITS-1:0]           r_b_sum;
    logic [COL_BITS-1:0]           r_a_col;
    logic [COL_BITS-1:0]           r_b_col;
    logic [bxf_pkg::ROW_BITS-1:0]  r_slot_row;
    logic                          r_a_last_in;
    logic                          r_a_frame;
    logic                          r_b_frame;

    logic                          r_o_valid;
    logic [PROD_BITS-1:0]          r_o_prod;
    logic [COL_BITS-1:0]           r_o_col;
    logic [bxf_pkg::ROW_BITS-1:0]  r_o_row;
    logic                          r_o_last_in;
    logic                          r_o_frame;

    logic                 out_free;
    logic                 drain;
    logic                 take_fire;
    logic                 load;
    logic [CS_BITS-1:0]   col_sum;
    logic [SUM_BITS-1:0]  sum_a;
    logic [SUM_BITS-1:0]  sum_b;
    logic [COL_BITS-1:0]  col_a;

    assign out_free  = !r_o_valid || i_ready;
    assign drain     = r_a_v && out_free;
    // slots must be empty after this cycle's drain
    assign o_take    = !r_a_v || (out_free && !r_b_v);
    assign take_fire = i_s1_valid && o_take;
    assign load      = take_fire && i_flags.rows_ready && !i_flags.first_col;

    assign col_sum = CS_BITS'(i_sample) + CS_BITS'(i_above) + CS_BITS'(i_two_above);

    // edge column counts twice at the left border
    assign sum_a = i_flags.second_col
                 ? (SUM_BITS'(r_cs_last) << 1) + SUM_BITS'(col_sum)
                 : SUM_BITS'(r_cs_prev) + SUM_BITS'(r_cs_last) + SUM_BITS'(col_sum);
    assign sum_b = (SUM_BITS'(col_sum) << 1) + SUM_BITS'(r_cs_last);
    assign col_a = i_flags.second_col ? '0 : i_col - COL_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cs_prev <= '0;
            r_cs_last <= '0;
        end else if (take_fire && i_flags.rows_ready) begin
            r_cs_prev <= r_cs_last;
            r_cs_last <= col_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (load) begin
            r_a_v <= 1'b1;
            r_b_v <= i_flags.last_col;
        end else if (drain) begin
            r_a_v <= r_b_v;
            r_b_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a_sum     <= sum_a;
            r_a_col     <= col_a;
            r_a_last_in <= !i_flags.last_col;
            r_a_frame   <= 1'b0;
            r_b_sum     <= sum_b;
            r_b_col     <= i_col;
            r_b_frame   <= i_flags.frame_end;
            r_slot_row  <= i_row - bxf_pkg::ROW_BITS'(1);
        end else if (drain) begin
            // advance the right-edge result into the head slot
            r_a_sum     <= r_b_sum;
            r_a_col     <= r_b_col;
            r_a_last_in <= 1'b1;
            r_a_frame   <= r_b_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_o_prod    <= PROD_BITS'(r_a_sum) * PROD_BITS'(RECIP);
            r_o_col     <= r_a_col;
            r_o_row     <= r_slot_row;
            r_o_last_in <= r_a_last_in;
            r_o_frame   <= r_a_frame;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_value         = r_o_prod[K +: SAMPLE_BITS];
    assign o_out_row       = r_o_row;
    assign o_out_col       = r_o_col;
    assign o_last_of_input = r_o_last_in;
    assign o_last_of_frame = r_o_frame;

    a_b_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> r_a_v)
        else $error("second result slot filled without a head result");

    a_no_take_with_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !r_b_v)
        else $error("window took a word while two results were pending");

    a_edge_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_fire && i_flags.rows_ready && i_flags.last_col) |=> (r_a_v && r_b_v))
        else $error("last column word did not queue two results");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_frame) |-> r_o_last_in)
        else $error("frame end result not marked last of its word");

endmodule

// File: sv/box_filter_3x3_stream.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 box filter.
//
// Takes one sample word per clock in raster order while o_ready is high and
// returns floor(sum/9) of the 3x3 window for every interior row, one column behind
// the input, with the edge column doubled at the left and right borders. Rows 0
// and row_count-1 are halo. The word in the last column of a row from row 2 on
// gives two results, and a word after it waits in the read stage with o_ready low
// while the single result port drains the right-edge result. An accepted word
// passes the line buffer read, the window update and the divide-by-nine multiply
// registers on the way to its first result. Both line buffers share one memory of
// MAX_WIDTH words, read and written once per word; no clearing pass runs after
// reset. A write to the row width or row count register restarts the grid and
// must be issued only while the block is idle.
module box_filter_3x3_stream #(
    parameter int MAX_WIDTH   = bxf_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = bxf_pkg::SAMPLE_BITS_DEF,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int WREG_BITS  = $clog2(MAX_WIDTH + 1),
    localparam int CFG_BITS   = (WREG_BITS > bxf_pkg::ROW_BITS) ? WREG_BITS
                                                                : bxf_pkg::ROW_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bxf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [SAMPLE_BITS-1:0]            o_value,
    output logic [bxf_pkg::ROW_BITS-1:0]      o_out_row,
    output logic [COL_BITS-1:0]               o_out_col,
    output logic                              o_last_of_input,
    output logic                              o_last_of_frame
);

    localparam int WIDTH_RST = (bxf_pkg::ROW_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                    : bxf_pkg::ROW_WIDTH_RST;

    logic [WREG_BITS-1:0]          r_row_width;
    logic [bxf_pkg::ROW_BITS-1:0]  r_row_count;
    logic [COL_BITS-1:0]           r_col;
    logic [bxf_pkg::ROW_BITS-1:0]  r_row;

    logic                          r_s1_v;
    logic [SAMPLE_BITS-1:0]        r_s1_sample;
    logic [COL_BITS-1:0]           r_s1_col;
    logic [bxf_pkg::ROW_BITS-1:0]  r_s1_row;
    bxf_pkg::t_item_flags          r_s1_flags;

    logic                          cfg_fire;
    logic                          clear;
    logic                          in_fire;
    logic                          take;
    logic                          s1_fire;
    logic [COL_BITS-1:0]           last_col;
    logic [bxf_pkg::ROW_BITS-1:0]  last_row;
    logic                          at_last_col;
    logic [2*SAMPLE_BITS-1:0]      mem_rd;
    bxf_pkg::t_item_flags          flags;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign clear       = cfg_fire && ((i_cfg_index == bxf_pkg::REG_ROW_WIDTH)
                                   || (i_cfg_index == bxf_pkg::REG_ROW_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WREG_BITS'(WIDTH_RST);
            r_row_count <= bxf_pkg::ROW_BITS'(bxf_pkg::ROW_COUNT_RST);
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                bxf_pkg::REG_ROW_WIDTH: r_row_width <= i_cfg_data[WREG_BITS-1:0];
                bxf_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data[bxf_pkg::ROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp the registers to the supported grid shape
    always_comb begin
        if (r_row_width < WREG_BITS'(2)) begin
            last_col = COL_BITS'(1);
        end else if (r_row_width > WREG_BITS'(MAX_WIDTH)) begin
            last_col = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_BITS'(r_row_width - WREG_BITS'(1));
        end
        if (r_row_count < bxf_pkg::ROW_BITS'(3)) begin
            last_row = bxf_pkg::ROW_BITS'(2);
        end else begin
            last_row = r_row_count - bxf_pkg::ROW_BITS'(1);
        end
    end

    assign s1_fire = r_s1_v && take;
    assign o_ready = !r_s1_v || take;
    assign in_fire = i_valid && o_ready;

    assign at_last_col       = (r_col >= last_col);
    assign flags.rows_ready  = (r_row >= bxf_pkg::ROW_BITS'(2));
    assign flags.first_col   = (r_col == '0);
    assign flags.second_col  = (r_col == COL_BITS'(1));
    assign flags.last_col    = at_last_col;
    assign flags.frame_end   = at_last_col && (r_row == last_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (at_last_col) begin
                r_col <= '0;
                r_row <= (r_row >= last_row) ? '0 : r_row + bxf_pkg::ROW_BITS'(1);
            end else begin
                r_col <= r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_ready) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_sample <= i_sample;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_flags  <= flags;
        end
    end

    // entry holds {two rows above, row above}; shift the column down on write-back
    bxf_line_mem #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * SAMPLE_BITS)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .o_rd_data (mem_rd),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({mem_rd[SAMPLE_BITS-1:0], r_s1_sample})
    );

    bxf_window #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_BITS    (COL_BITS)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (clear),
        .i_s1_valid      (r_s1_v),
        .o_take          (take),
        .i_sample        (r_s1_sample),
        .i_above         (mem_rd[SAMPLE_BITS-1:0]),
        .i_two_above     (mem_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_col           (r_s1_col),
        .i_row           (r_s1_row),
        .i_flags         (r_s1_flags),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_value         (o_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_input (o_last_of_input),
        .o_last_of_frame (o_last_of_frame)
    );

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_col <= last_col))
        else $error("column position beyond the row width");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !take) |=> (r_s1_v && $stable(r_s1_col)))
        else $error("stalled word left the read stage");

    a_wb_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s1_fire) |-> (r_col != r_s1_col))
        else $error("line buffer read and write-back hit the same column");

endmodule

// File: dv/tb_box_filter_3x3_stream.sv
`timescale 1ns / 1ps
// Self-checking testbench of the streaming 3x3 box filter with a built-in window predictor.
module tb_box_filter_3x3_stream;

    localparam int WMAX          = bxf_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int TOTAL_ITEMS   = 1850;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [bxf_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [bxf_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [15:0] value;
        logic [15:0] row;
        logic [9:0]  col;
        logic        last_in;
        logic        last_frame;
    } t_mean;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [bxf_pkg::CFG_IDX_BITS-1:0] i_cfg_index = bxf_pkg::REG_ROW_WIDTH;
    logic [15:0]                      i_cfg_data  = '0;
    logic                             i_valid     = 1'b0;
    logic                             o_ready;
    logic [15:0]                      i_sample    = '0;
    logic                             o_valid;
    logic                             i_ready     = 1'b0;
    logic [15:0]                      o_value;
    logic [15:0]                      o_out_row;
    logic [9:0]                       o_out_col;
    logic                             o_last_of_input;
    logic                             o_last_of_frame;

    box_filter_3x3_stream dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_value         (o_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_input (o_last_of_input),
        .o_last_of_frame (o_last_of_frame)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic [10:0] width_reg = 11'(bxf_pkg::ROW_WIDTH_RST);
    logic [15:0] rows_reg  = 16'(bxf_pkg::ROW_COUNT_RST);
    logic [15:0] line_up   [WMAX];
    logic [15:0] line_up2  [WMAX];
    logic [17:0] col_sum   [3] = '{default: '0};
    int          col_pos = 0;
    int          row_pos = 0;

    t_mean expected_means[$];
    int    error_count = 0;
    bit    tx_idle     = 1'b1;
    bit    rx_idle     = 1'b1;
    int    hold_asks   = 0;
    int    hold_done   = 0;
    int    rx_wait     = 0;
    int    quiet_cycles = 0;
    int    items_sent  = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    function automatic void apply_config(input logic [bxf_pkg::CFG_IDX_BITS-1:0] idx,
                                         input logic [15:0] data);
        bit hit;
        hit = 1'b1;
        case (idx)
            bxf_pkg::REG_ROW_WIDTH: width_reg = data[10:0];
            bxf_pkg::REG_ROW_COUNT: rows_reg = data;
            default: hit = 1'b0;
        endcase
        // any listed register restarts the grid; line buffers survive
        if (hit) begin
            col_sum = '{default: '0};
            col_pos = 0;
            row_pos = 0;
        end
    endfunction

    function automatic void push_mean(input int sum, input int col, input bit li,
                                      input bit lf);
        t_mean m;
        m.value      = 16'(sum / 9);
        m.row        = 16'(row_pos - 1);
        m.col        = 10'(col);
        m.last_in    = li;
        m.last_frame = lf;
        expected_means.push_back(m);
    endfunction

    function automatic void predict_box_mean(input logic [15:0] s);
        int w, h, c;
        bit last_col;
        w = (width_reg < 2) ? 2 : (width_reg > WMAX) ? WMAX : int'(width_reg);
        h = (rows_reg < 3) ? 3 : int'(rows_reg);
        c = col_pos;
        if (row_pos >= 2) begin
            last_col   = (c == w - 1);
            col_sum[0] = col_sum[1];
            col_sum[1] = col_sum[2];
            col_sum[2] = 18'(int'(line_up2[c]) + int'(line_up[c]) + int'(s));
            // left edge doubles column 0, right edge doubles the last column
            if (c == 1)
                push_mean(2 * int'(col_sum[1]) + int'(col_sum[2]), 0, !last_col, 1'b0);
            else if (c >= 2)
                push_mean(int'(col_sum[0]) + int'(col_sum[1]) + int'(col_sum[2]),
                          c - 1, !last_col, 1'b0);
            if (last_col)
                push_mean(2 * int'(col_sum[2]) + int'(col_sum[1]), c, 1'b1,
                          row_pos == h - 1);
        end
        line_up2[c] = line_up[c];
        line_up[c]  = s;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic check_result();
        t_mean e;
        if (expected_means.size() == 0) begin
            report($sformatf("unexpected result row %0d col %0d value %h",
                             o_out_row, o_out_col, o_value));
            return;
        end
        e = expected_means.pop_front();
        if (o_value !== e.value)
            report($sformatf("value r%0d c%0d: got %h want %h", e.row, e.col, o_value, e.value));
        if (o_out_row !== e.row)
            report($sformatf("out_row: got %0d want %0d", o_out_row, e.row));
        if (o_out_col !== e.col)
            report($sformatf("out_col r%0d: got %0d want %0d", e.row, o_out_col, e.col));
        if (o_last_of_input !== e.last_in)
            report($sformatf("last_of_input r%0d c%0d: got %b want %b",
                             e.row, e.col, o_last_of_input, e.last_in));
        if (o_last_of_frame !== e.last_frame)
            report($sformatf("last_of_frame r%0d c%0d: got %b want %b",
                             e.row, e.col, o_last_of_frame, e.last_frame));
    endtask

    // Result side: check each accepted word, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_result();
        if (rx_wait > 0) begin
            rx_wait--;
            i_ready <= 1'b0;
        end else if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            rx_wait   = HOLD_CYCLES - 1;
            i_ready  <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rx_wait  = rand_gap();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [15:0] s);
        int gap;
        gap = tx_idle ? rand_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        predict_box_mean(s);
        items_sent++;
    endtask

    // Hold input, wait for every expected word, then let the pipeline settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bxf_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [15:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_config(idx, data);
    endtask

    task automatic test_reset_config();
        // row 0 of the default 1024-wide grid: buffers fill, nothing comes out
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(rand_sample());
        send_sample(rand_sample());
    endtask

    task automatic test_smallest_grid();
        write_reg(bxf_pkg::REG_ROW_WIDTH, 16'h0001);     // below range, acts as 2
        write_reg(bxf_pkg::REG_ROW_COUNT, 16'h0000);     // below range, acts as 3
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        // wrap into the next grid
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
    endtask

    task automatic test_unlisted_index();
        send_sample(rand_sample());
        send_sample(rand_sample());
        write_reg(REG_SPARE_A, 16'($urandom));
        send_sample(rand_sample());
        send_sample(rand_sample());
        write_reg(REG_SPARE_B, 16'hFFFF);
        send_sample(rand_sample());
        send_sample(rand_sample());
    endtask

    task automatic test_restart_mid_grid();
        write_reg(bxf_pkg::REG_ROW_WIDTH, 16'h0003);
        write_reg(bxf_pkg::REG_ROW_COUNT, 16'h0003);
        send_sample(rand_sample());
        send_sample(rand_sample());
        send_sample(rand_sample());
        write_reg(bxf_pkg::REG_ROW_COUNT, 16'h0003);
        repeat (9) send_sample(rand_sample());
    endtask

    task automatic test_widest_grid();
        write_reg(bxf_pkg::REG_ROW_WIDTH, 16'hFFFF);     // 2047 clamps to full width
        write_reg(bxf_pkg::REG_ROW_COUNT, 16'h0002);
        // a full row and a few words of the next: no result may come out
        repeat (WMAX + 16) send_sample(rand_sample());
    endtask

    task automatic test_output_backpressure();
        int w;
        w = $urandom_range(4, 12);
        write_reg(bxf_pkg::REG_ROW_WIDTH, 16'(w));
        write_reg(bxf_pkg::REG_ROW_COUNT, 16'd6);
        tx_idle = 1'b0;
        hold_asks++;
        repeat (2 * 6 * w) send_sample(rand_sample());
        // pause the sender until the last word is out
        drain_results();
        repeat (6 * w) send_sample(rand_sample());
        tx_idle = 1'b1;
    endtask

    task automatic test_random_grids();
        int w, h, n, r;
        logic [15:0] wdata, hdata;
        while (items_sent < TOTAL_ITEMS) begin
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 9);
            w = (r == 0) ? $urandom_range(17, 200) : $urandom_range(2, 16);
            h = (r == 1) ? 65535 : $urandom_range(3, 8);
            wdata = {5'($urandom), 11'(w)};
            if (w == 2 && $urandom_range(0, 1) == 0)
                wdata[10:0] = 11'($urandom_range(0, 1));
            hdata = 16'(h);
            if (h == 3 && $urandom_range(0, 1) == 0)
                hdata = 16'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 0) begin
                write_reg(bxf_pkg::REG_ROW_WIDTH, wdata);
                write_reg(bxf_pkg::REG_ROW_COUNT, hdata);
            end else begin
                write_reg(bxf_pkg::REG_ROW_COUNT, hdata);
                write_reg(bxf_pkg::REG_ROW_WIDTH, wdata);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
            if (h == 65535)
                n = w * $urandom_range(3, 5) + $urandom_range(0, w - 1);
            else
                n = w * h * $urandom_range(1, 2)
                    + (($urandom_range(0, 3) == 0) ? $urandom_range(0, w * h - 1) : 0);
            // keep the whole run near its item budget
            if (n > TOTAL_ITEMS - items_sent)
                n = TOTAL_ITEMS - items_sent;
            repeat (n) send_sample(rand_sample());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_smallest_grid();
        test_unlisted_index();
        test_restart_mid_grid();
        test_widest_grid();
        test_output_backpressure();
        test_random_grids();
        drain_results();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
